// ===== rtl/core/sha1_pkg.sv =====
// SHA-1 shared types and constants.
`default_nettype none
package sha1_pkg;
	localparam logic [31:0] IV0 = 32'h67452301;
	localparam logic [31:0] IV1 = 32'hEFCDAB89;
	localparam logic [31:0] IV2 = 32'h98BADCFE;
	localparam logic [31:0] IV3 = 32'h10325476;
	localparam logic [31:0] IV4 = 32'hC3D2E1F0;
	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;
	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam int QUEUE_DEPTH = 4;

	// word handed from front to back
	typedef struct packed {
		logic [31:0] word;
		logic        blk_end;   // 16th word of a block
		logic        msg_end;   // last word of the message
	} sha1_xfer_t;
endpackage
`default_nettype wire

// ===== rtl/core/sha1_message_digest_unit.sv =====
// SHA-1 digest unit top level: front end, word queue, compression back end.
//
// Channel   Dir  Handshake       Payload
// input     in   push / full     data_word, byte_count, last_word
// digest    out  empty / pop     digest_word0..digest_word4
//
// The back end takes one word per cycle while loading, then runs 80 rounds
// plus one chaining add per 64-byte block, taking no words until they are done.
// The back end's single round unit, shared by all 80 rounds, bounds throughput.
// On a last word the front end issues 2..18 pad and length words, one per cycle
// while the queue has room; full stays high until the length words are out.
// Reset clears chaining words to the SHA-1 IV and all control state.
// full stalls input while padding or when the queue is full; a waiting
// digest blocks the next message's compression, not its queuing.
`default_nettype none
module sha1_message_digest_unit #(
	parameter int QDEPTH = sha1_pkg::QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [31:0] data_word,
	input  wire logic [2:0]  byte_count,
	input  wire logic        last_word,
	output logic             empty,
	input  wire logic        pop,
	output logic [31:0]      digest_word0,
	output logic [31:0]      digest_word1,
	output logic [31:0]      digest_word2,
	output logic [31:0]      digest_word3,
	output logic [31:0]      digest_word4
);
	import sha1_pkg::*;

	logic       f_valid, f_ready, b_valid, b_ready;
	sha1_xfer_t f_xfer, b_xfer;

	sha1_front u_front (
		.clk, .arst_n, .push, .full, .data_word, .byte_count, .last_word,
		.xfer_valid(f_valid), .xfer(f_xfer), .xfer_ready(f_ready)
	);

	sha1_queue #(.DEPTH(QDEPTH)) u_queue (
		.clk, .arst_n,
		.in_valid(f_valid), .in_data(f_xfer), .in_ready(f_ready),
		.out_valid(b_valid), .out_data(b_xfer), .out_ready(b_ready)
	);

	sha1_back u_back (
		.clk, .arst_n, .in_valid(b_valid), .in_data(b_xfer), .in_ready(b_ready),
		.empty, .pop, .digest_word0, .digest_word1, .digest_word2,
		.digest_word3, .digest_word4
	);

	// a message end word always closes a block
	a_end_blk: assert property (@(posedge clk) disable iff (!arst_n)
		(f_valid && f_xfer.msg_end) |-> f_xfer.blk_end)
		else $error("message end not on block boundary");

	// a shown digest holds until popped
	a_dig_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(digest_word0) && $stable(digest_word4)))
		else $error("digest changed while waiting");

	// the back end never takes a word while the digest waits
	a_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !b_ready)
		else $error("word taken while digest pending");
endmodule
`default_nettype wire

// ===== rtl/core/sha1_front.sv =====
// Front end: takes input words, pads, appends length, emits schedule words.
`default_nettype none
module sha1_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic [31:0]        data_word,
	input  wire logic [2:0]         byte_count,
	input  wire logic               last_word,
	output logic                    xfer_valid,
	output sha1_pkg::sha1_xfer_t    xfer,
	input  wire logic               xfer_ready
);
	import sha1_pkg::*;

	typedef enum logic [1:0] {ST_DATA, ST_EXTRA, ST_ZERO, ST_LEN} st_t;

	st_t         state_q;
	logic [3:0]  fill_q;
	logic [60:0] bytes_q;
	logic        len_lo_q;
	logic [31:0] extra_q;
	logic [2:0]  n_eff;
	logic [31:0] keep, pad, last_val;
	logic [63:0] bits;
	logic        fire;

	always_comb begin
		n_eff = (byte_count > 3'd4) ? 3'd4 : byte_count;
		case (n_eff)
			3'd0: begin keep = 32'h0;        pad = {PAD_BYTE, 24'h0}; end
			3'd1: begin keep = 32'hFF000000; pad = {8'h0, PAD_BYTE, 16'h0}; end
			3'd2: begin keep = 32'hFFFF0000; pad = {16'h0, PAD_BYTE, 8'h0}; end
			3'd3: begin keep = 32'hFFFFFF00; pad = {24'h0, PAD_BYTE}; end
			default: begin keep = 32'hFFFFFFFF; pad = 32'h0; end
		endcase
		last_val = (data_word & keep) | pad;
		bits = {bytes_q, 3'b000};
	end

	assign full = (state_q != ST_DATA) || !xfer_ready;
	assign fire = xfer_valid && xfer_ready;

	always_comb begin
		xfer_valid = 1'b0;
		xfer.word = 32'h0;
		xfer.blk_end = (fill_q == 4'd15);
		xfer.msg_end = 1'b0;
		case (state_q)
			ST_DATA: begin
				xfer_valid = push;
				xfer.word = last_word ? last_val : data_word;
			end
			ST_EXTRA: begin
				xfer_valid = 1'b1;
				xfer.word = extra_q;
			end
			ST_ZERO: begin
				xfer_valid = 1'b1;
			end
			ST_LEN: begin
				xfer_valid = 1'b1;
				xfer.word = len_lo_q ? bits[31:0] : bits[63:32];
				xfer.msg_end = len_lo_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_DATA;
			fill_q <= '0;
			bytes_q <= '0;
			len_lo_q <= 1'b0;
			extra_q <= '0;
		end else if (fire) begin
			fill_q <= fill_q + 4'd1;
			case (state_q)
				ST_DATA: begin
					if (!last_word) begin
						bytes_q <= bytes_q + 61'd4;
					end else begin
						bytes_q <= bytes_q + {58'd0, n_eff};
						if (n_eff == 3'd4) begin
							extra_q <= {PAD_BYTE, 24'h0};
							state_q <= ST_EXTRA;
						end else if (fill_q == 4'd13) begin
							state_q <= ST_LEN;
						end else begin
							state_q <= ST_ZERO;
						end
					end
				end
				ST_EXTRA: state_q <= (fill_q == 4'd13) ? ST_LEN : ST_ZERO;
				ST_ZERO: if (fill_q == 4'd13) state_q <= ST_LEN;
				ST_LEN: begin
					len_lo_q <= !len_lo_q;
					if (len_lo_q) begin
						state_q <= ST_DATA;
						bytes_q <= '0;
						fill_q <= '0;
					end
				end
				default: state_q <= ST_DATA;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/sha1_queue.sv =====
// Small FIFO between front and back ends.
`default_nettype none
module sha1_queue #(
	parameter int DEPTH = sha1_pkg::QUEUE_DEPTH
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  sha1_pkg::sha1_xfer_t in_data,
	output logic                 in_ready,
	output logic                 out_valid,
	output sha1_pkg::sha1_xfer_t out_data,
	input  wire logic            out_ready
);
	import sha1_pkg::*;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	sha1_xfer_t      mem_q [DEPTH];
	logic [AW-1:0]   wr_q, rd_q;
	logic [AW:0]     cnt_q;
	logic            wr, rd;

	assign in_ready  = (cnt_q != (AW+1)'(DEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_data  = mem_q[rd_q];
	assign wr = in_valid && in_ready;
	assign rd = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wr_q] <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + AW'(1);
			if (rd) rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/sha1_back.sv =====
// Back end: 16-word window, 80-round compression, chaining and digest output.
`default_nettype none
module sha1_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  sha1_pkg::sha1_xfer_t in_data,
	output logic                 in_ready,
	output logic                 empty,
	input  wire logic            pop,
	output logic [31:0]          digest_word0,
	output logic [31:0]          digest_word1,
	output logic [31:0]          digest_word2,
	output logic [31:0]          digest_word3,
	output logic [31:0]          digest_word4
);
	import sha1_pkg::*;

	typedef enum logic [1:0] {ST_LOAD, ST_ROUND, ST_ADD, ST_OUT} st_t;

	st_t         state_q;
	logic [31:0] w_q [16];
	logic [31:0] h_q [5];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [6:0]  rnd_q;
	logic        fin_q;
	logic [31:0] w_new, f, k, t, wt;
	logic        take;

	assign in_ready = (state_q == ST_LOAD);
	assign take = in_valid && in_ready;
	assign empty = (state_q != ST_OUT);
	assign digest_word0 = h_q[0];
	assign digest_word1 = h_q[1];
	assign digest_word2 = h_q[2];
	assign digest_word3 = h_q[3];
	assign digest_word4 = h_q[4];

	// window kept as a shift line: w_q[0] is the oldest word
	always_comb begin
		w_new = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
		w_new = {w_new[30:0], w_new[31]};
		wt = (rnd_q < 7'd16) ? w_q[0] : w_new;
		if (rnd_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q); k = K0;
		end else if (rnd_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q; k = K1;
		end else if (rnd_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q); k = K2;
		end else begin
			f = b_q ^ c_q ^ d_q; k = K3;
		end
		t = {a_q[26:0], a_q[31:27]} + f + e_q + k + wt;
	end

	always_ff @(posedge clk) begin
		if (take || state_q == ST_ROUND) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= take ? in_data.word : wt;
		end
		if (take && in_data.blk_end) begin
			a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3]; e_q <= h_q[4];
		end else if (state_q == ST_ROUND) begin
			a_q <= t; b_q <= a_q; c_q <= {b_q[1:0], b_q[31:2]}; d_q <= c_q; e_q <= d_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			rnd_q <= '0;
			fin_q <= 1'b0;
			h_q[0] <= IV0; h_q[1] <= IV1; h_q[2] <= IV2; h_q[3] <= IV3; h_q[4] <= IV4;
		end else begin
			case (state_q)
				ST_LOAD: if (take && in_data.blk_end) begin
					fin_q <= in_data.msg_end;
					rnd_q <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == 7'd79) state_q <= ST_ADD;
				end
				ST_ADD: begin
					h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q; h_q[3] <= h_q[3] + d_q;
					h_q[4] <= h_q[4] + e_q;
					state_q <= fin_q ? ST_OUT : ST_LOAD;
				end
				ST_OUT: if (pop) begin
					h_q[0] <= IV0; h_q[1] <= IV1; h_q[2] <= IV2; h_q[3] <= IV3; h_q[4] <= IV4;
					state_q <= ST_LOAD;
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end
endmodule
`default_nettype wire
